@@ design/double_ended_queue_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Clocked on clk, quiet while rst_n is low; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked at every clock edge out of reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

@@ design/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Sizes, codes, types and ring index helpers shared by the deque unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_W     = 32;   // stored word width
  localparam int VAL_W      = 32;   // value / element field width
  localparam int ACT_W      = 3;
  localparam int OCC_W      = 11;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;   // element + occupancy, padded to bytes
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    sum_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);
  localparam sum_t SUM_WRAP = sum_t'(DEPTH);

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_SEEK
  } state_t;

  typedef struct packed {
    logic  wr_en;
    word_t wr_data;
  } ring_req_t;

  typedef struct packed {
    idx_t  head_pos;
    word_t head_data;
  } ring_stat_t;

  typedef struct packed {
    logic [VAL_W-1:0] element;
    logic [OCC_W-1:0] occupancy;
    logic [ST_W-1:0]  status;
  } result_t;

  // (a + b) mod DEPTH, a < DEPTH, b <= DEPTH
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    if (s >= SUM_WRAP) begin
      s = s - SUM_WRAP;
    end
    return idx_t'(s);
  endfunction

  function automatic idx_t ring_dec(idx_t a);
    return (a == '0) ? IDX_LAST : a - idx_t'(1);
  endfunction

  // sign-extend or truncate the value field into a stored word
  function automatic word_t to_word(logic [VAL_W-1:0] v);
    word_t w;
    for (int i = 0; i < DATA_W; i++) begin
      w[i] = (i < VAL_W) ? v[i] : v[VAL_W-1];
    end
    return w;
  endfunction

  // low VAL_W bits of a stored word, zero-filled
  function automatic logic [VAL_W-1:0] to_elem(word_t w);
    logic [VAL_W-1:0] e;
    for (int i = 0; i < VAL_W; i++) begin
      e[i] = (i < DATA_W) ? w[i] : 1'b0;
    end
    return e;
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(cnt_t c);
    logic [OCC_W-1:0] o;
    for (int i = 0; i < OCC_W; i++) begin
      o[i] = (i < CNT_W) ? c[i] : 1'b0;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the rotating ring: takes its neighbor's word each
// cycle, or a new word when loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic  clk,
  input  wire word_t shift_in,
  input  wire logic  ld_en,
  input  wire word_t ld_data,
  output word_t      word_q
);

  word_t word_r;
  word_t word_nxt;

  assign word_nxt = ld_en ? ld_data : shift_in;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

`default_nettype wire

@@ design/deq_ring.sv @@
// ----------------------------------------------------------------------------
// deq_ring
// DEPTH cells in a closed chain that rotates by one cell every cycle.
// Cell 0 is the access port; head_pos names the ring address sitting there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ring
  import deq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ring_req_t req,
  output ring_stat_t     stat
);

  word_t cell_q [DEPTH];
  idx_t  pos_r;
  idx_t  pos_nxt;

  // address at cell k is head_pos - k; a write lands in cell 1, which
  // holds the current head address in the next cycle
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t sh_in;
    logic  ld;
    if (i == 0) begin : g_head
      assign sh_in = cell_q[DEPTH-1];
    end else begin : g_body
      assign sh_in = cell_q[i-1];
    end
    if (i == 1) begin : g_wr
      assign ld = req.wr_en;
    end else begin : g_nowr
      assign ld = 1'b0;
    end
    deq_cell u_cell (
      .clk      (clk),
      .shift_in (sh_in),
      .ld_en    (ld),
      .ld_data  (req.wr_data),
      .word_q   (cell_q[i])
    );
  end

  assign pos_nxt = (pos_r == IDX_LAST) ? '0 : pos_r + idx_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign stat.head_pos  = pos_r;
  assign stat.head_data = cell_q[0];

endmodule

`default_nettype wire

@@ design/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Front index, count and the per-word sequencer: decode, wait for the
// target entry to reach the ring head, then read or write it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module deq_ctrl
  import deq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] in_action,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             out_free,
  input  wire ring_stat_t       stat,
  output ring_req_t             req,
  output logic                  res_load,
  output result_t               res
);

  state_t            state_r, state_nxt;
  idx_t              front_r, front_nxt;
  cnt_t              cnt_r, cnt_nxt;
  logic [ACT_W-1:0]  act_r;
  word_t             val_r;
  idx_t              tgt_r, tgt_nxt;
  logic              acc_r, acc_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic              take;
  logic              is_push;

  assign is_push = (act_r == ACT_PUSH_FRONT) || (act_r == ACT_PUSH_BACK);

  // decode of the incoming word against the current front and count
  always_comb begin
    tgt_nxt    = front_r;
    acc_nxt    = 1'b0;
    status_nxt = ST_OK;
    unique case (in_action)
      ACT_PUSH_FRONT: begin
        if (cnt_r == CNT_FULL) begin
          status_nxt = ST_FULL;
        end else begin
          acc_nxt = 1'b1;
          tgt_nxt = ring_dec(front_r);
        end
      end
      ACT_PUSH_BACK: begin
        if (cnt_r == CNT_FULL) begin
          status_nxt = ST_FULL;
        end else begin
          acc_nxt = 1'b1;
          tgt_nxt = ring_add(front_r, cnt_r);
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          acc_nxt = 1'b1;
          tgt_nxt = front_r;
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          acc_nxt = 1'b1;
          tgt_nxt = ring_add(front_r, cnt_r - cnt_t'(1));
        end
      end
      default: begin
        // unused action: no access, ok status
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    take        = 1'b0;
    res_load    = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_data = val_r;
    front_nxt   = front_r;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          take      = 1'b1;
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        if ((!acc_r || (stat.head_pos == tgt_r)) && out_free) begin
          res_load  = 1'b1;
          req.wr_en = acc_r && is_push;
          state_nxt = S_IDLE;
          if (acc_r) begin
            unique case (act_r)
              ACT_PUSH_FRONT: begin
                front_nxt = tgt_r;
                cnt_nxt   = cnt_r + cnt_t'(1);
              end
              ACT_PUSH_BACK: begin
                cnt_nxt = cnt_r + cnt_t'(1);
              end
              ACT_POP_FRONT: begin
                front_nxt = ring_add(front_r, cnt_t'(1));
                cnt_nxt   = cnt_r - cnt_t'(1);
              end
              ACT_POP_BACK: begin
                cnt_nxt = cnt_r - cnt_t'(1);
              end
              default: begin
                // peeks leave the pointers alone
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.element   = (acc_r && !is_push) ? to_elem(stat.head_data) : '0;
  assign res.occupancy = to_occ(cnt_nxt);
  assign res.status    = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
    end else begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      if (take) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      act_r    <= in_action;
      val_r    <= to_word(in_value);
      tgt_r    <= tgt_nxt;
      status_r <= status_nxt;
    end
  end

  `DEQ_ASSERT(a_cnt_bound, cnt_r <= CNT_FULL, "element count above depth")
  `DEQ_ASSERT_IMPL(a_push_grows, res_load && acc_r && is_push, ##1 cnt_r == $past(cnt_r) + cnt_t'(1), "push did not grow count")
  `DEQ_ASSERT_IMPL(a_pop_front, res_load && acc_r && (act_r == ACT_POP_FRONT), ##1 front_r == ring_add($past(front_r), cnt_t'(1)), "pop front did not advance front")

endmodule

`default_nettype wire

@@ design/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words held in a rotating chain of storage cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                 | tuser
//  --------+-----+------------------------------------+--------------
//  in_     | in  | value[31:0]                        | action[2:0]
//  out_    | out | element[31:0], occupancy[42:32],   | status[1:0]
//          |     | zero pad[47:43]                    |
//
//  Sequencing: a word that needs no entry (error status or unused action)
//  does not wait for the ring; otherwise the sequencer waits for
//  the ring rotation to bring the target entry to cell 0.
//  Reset: rst_n low clears front index, count, ring position, sequencer
//  state and the result valid flag; stored words are left as they are,
//  no clearing pass.
//  Stalls: a finished result sits in the output register and the next word
//  is accepted meanwhile; the sequencer holds that word until the register
//  drains, and if its entry passes cell 0 while blocked it waits one more
//  full rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit
  import deq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // value[31:0]
  input  wire logic [ACT_W-1:0]      in_tuser,   // action[2:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // element[31:0], occupancy[42:32]
  output logic [ST_W-1:0]            out_tuser   // status[1:0]
);

  ring_req_t  req;
  ring_stat_t stat;
  result_t    res;
  logic       res_load;
  logic       out_free;

  logic       out_valid_r;
  result_t    res_r;

  // storage: cells rotate continuously, cell 0 is the access port
  deq_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .stat  (stat)
  );

  // sequencer and pointers
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_value  (in_tdata[VAL_W-1:0]),
    .out_free  (out_free),
    .stat      (stat),
    .req       (req),
    .res_load  (res_load),
    .res       (res)
  );

  // output register; the slot counts as free when it drains this cycle
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - OCC_W){1'b0}}, res_r.occupancy, res_r.element};
  assign out_tuser  = res_r.status;

  // a full-status result always reports a full deque, an empty one zero
  `DEQ_ASSERT_IMPL(a_full_occ, out_valid_r && (res_r.status == ST_FULL), res_r.occupancy == to_occ(CNT_FULL), "full status with partial occupancy")
  `DEQ_ASSERT_IMPL(a_empty_occ, out_valid_r && (res_r.status == ST_EMPTY), res_r.occupancy == '0, "empty status with nonzero occupancy")
  // a stalled result holds still
  `DEQ_ASSERT_IMPL(a_out_hold, out_valid_r && !out_tready, ##1 (out_valid_r && $stable(res_r)), "result changed while stalled")

endmodule

`default_nettype wire
